// ----- src/baa_pkg.sv -----
// Package for the aligned bump allocator: field types, request, response and
// state structs, and the function and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package baa_pkg;

    typedef logic [16:0] t_len;
    typedef logic [15:0] t_offset;
    typedef logic [31:0] t_count;
    typedef logic [1:0]  t_status;

    localparam logic   FUNC_ALLOC = 1'b0;
    localparam logic   FUNC_RESET = 1'b1;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_INVALID = 2'd1;
    localparam t_status ST_LIMIT   = 2'd2;

    localparam t_len CAP_RESET = 17'h10000;

    typedef struct packed {
        logic func;
        t_len size;
        t_len alignment;
    } t_req;

    typedef struct packed {
        t_status status;
        t_offset offset;
        t_len    used_now;
        t_len    remaining;
        t_len    peak_now;
        t_count  grants_now;
    } t_rsp;

    typedef struct packed {
        t_len   used;
        t_len   peak;
        t_count grants;
    } t_state;

endpackage

`default_nettype wire

// ----- src/baa_ifs.sv -----
// Valid/ready channel interfaces for the allocator request and response items.
// Depends on baa_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface baa_req_if;
    import baa_pkg::*;

    logic valid;
    logic ready;
    logic func;
    t_len size;
    t_len alignment;

    modport source (output valid, output func, output size, output alignment, input ready);
    modport sink (input valid, input func, input size, input alignment, output ready);
endinterface

interface baa_rsp_if;
    import baa_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_offset offset;
    t_len    used_now;
    t_len    remaining;
    t_len    peak_now;
    t_count  grants_now;

    modport source (output valid, output status, output offset, output used_now,
                    output remaining, output peak_now, output grants_now, input ready);
    modport sink (input valid, input status, input offset, input used_now,
                  input remaining, input peak_now, input grants_now, output ready);
endinterface

`default_nettype wire

// ----- src/baa_step.sv -----
// Combinational allocation step: validates one request item, aligns the fill,
// checks the fit and forms the next arena state and the response. Uses baa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module baa_step #(
    parameter int ADDR_BITS     = 16,
    parameter int DEFAULT_ALIGN = 8
) (
    input  baa_pkg::t_req   i_req,
    input  baa_pkg::t_state i_state,
    input  baa_pkg::t_len   i_capacity,
    output baa_pkg::t_state o_state,
    output baa_pkg::t_rsp   o_rsp
);
    import baa_pkg::*;

    localparam logic [17:0] LIMIT = (ADDR_BITS >= 17) ? 18'h20000 : (18'd1 << ADDR_BITS);
    localparam t_len        DEF_ALIGN = 17'(DEFAULT_ALIGN);

    logic [17:0] w_cap_wide;
    t_len        w_cap;
    t_len        w_align;
    t_len        w_amask;
    logic        w_pow2;
    logic [17:0] w_start;
    logic        w_fits;

    always_comb begin
        w_cap_wide = ({1'b0, i_capacity} > LIMIT) ? LIMIT : {1'b0, i_capacity};
        w_cap      = w_cap_wide[16:0];
        w_align    = (i_req.alignment == '0) ? DEF_ALIGN : i_req.alignment;
        w_amask    = w_align - 17'd1;
        w_pow2     = (w_align != '0) && ((w_align & w_amask) == '0);
        w_start    = ({1'b0, i_state.used} + {1'b0, w_amask}) & ~{1'b0, w_amask};
        w_fits     = (w_start <= {1'b0, w_cap}) &&
                     ({1'b0, i_req.size} <= ({1'b0, w_cap} - w_start));

        o_state       = i_state;
        o_rsp.status  = ST_OK;
        o_rsp.offset  = '0;

        if (i_req.func == FUNC_RESET) begin
            o_state.used   = '0;
            o_state.grants = '0;
        end else if ((i_req.size == '0) || !w_pow2) begin
            o_rsp.status = ST_INVALID;
        end else if (!w_fits) begin
            o_rsp.status = ST_LIMIT;
        end else begin
            o_rsp.offset = w_start[15:0];
            o_state.used = w_start[16:0] + i_req.size;
            if (o_state.used > i_state.peak) begin
                o_state.peak = o_state.used;
            end
            if (i_state.grants != '1) begin
                o_state.grants = i_state.grants + 32'd1;
            end
        end

        o_rsp.used_now   = o_state.used;
        o_rsp.remaining  = (o_state.used > w_cap) ? '0 : (w_cap - o_state.used);
        o_rsp.peak_now   = o_state.peak;
        o_rsp.grants_now = o_state.grants;
    end

endmodule

`default_nettype wire

// ----- src/bump_allocator_aligned.sv -----
// Top level of the aligned bump allocator: input register, allocation step,
// arena state and result register. Uses baa_pkg, baa_ifs and baa_step.
//
// The block takes one request item per clock cycle while the result side is not
// stalled, and returns exactly one response item for each, in order. A response
// passes through the input register and then the result register. The fill,
// peak and grant registers update in the same cycle that a request moves into
// the result register, so the align, add and compare path from the fill
// register back to itself sets the one-item-per-cycle rate.
// Ready toward the requester stays high while the result side keeps draining.
// The capacity register resets to 65536 and is written with i_cfg_we.
`timescale 1ns / 1ps
`default_nettype none

module bump_allocator_aligned #(
    parameter int ADDR_BITS     = 16,
    parameter int DEFAULT_ALIGN = 8
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_cfg_we,
    input  baa_pkg::t_len i_cfg_wdata,
    baa_req_if.sink       i_req,
    baa_rsp_if.source     o_rsp
);
    import baa_pkg::*;

    logic   r_in_valid;
    t_req   r_in;
    logic   r_out_valid;
    t_rsp   r_out;
    t_state r_state;
    t_len   r_capacity;

    t_state n_state;
    t_rsp   n_rsp;
    logic   w_out_load;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_out_load  = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_out_load;

    baa_step #(
        .ADDR_BITS     (ADDR_BITS),
        .DEFAULT_ALIGN (DEFAULT_ALIGN)
    ) u_step (
        .i_req      (r_in),
        .i_state    (r_state),
        .i_capacity (r_capacity),
        .o_state    (n_state),
        .o_rsp      (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_capacity  <= CAP_RESET;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_out_load) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready) begin
            r_in.func      <= i_req.func;
            r_in.size      <= i_req.size;
            r_in.alignment <= i_req.alignment;
        end
        if (w_out_load) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.offset     = r_out.offset;
    assign o_rsp.used_now   = r_out.used_now;
    assign o_rsp.remaining  = r_out.remaining;
    assign o_rsp.peak_now   = r_out.peak_now;
    assign o_rsp.grants_now = r_out.grants_now;

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (r_in.func == FUNC_RESET)) |=>
            ((r_state.used == '0) && (r_state.grants == '0)))
        else $error("Arena reset item did not clear fill and grant count.");

    a_peak_covers_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.peak >= r_state.used)
        else $error("Peak mark fell below the fill level.");

    a_peak_monotone: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_state.peak >= $past(r_state.peak)))
        else $error("Peak mark decreased outside reset.");

    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_load) |=> (r_in_valid && $stable(r_in)))
        else $error("Stalled request item was lost or changed.");

endmodule

`default_nettype wire

// ----- dv/bump_allocator_aligned_test.sv -----
// Self-checking testbench for bump_allocator_aligned: directed and random request items
// with a built-in predictor of the arena state. It depends on baa_pkg, baa_ifs and bump_allocator_aligned.
`timescale 1ns / 1ps

module bump_allocator_aligned_test;
    import baa_pkg::*;

    localparam int ADDR_BITS = 16;
    localparam int DEFAULT_ALIGN = 8;
    localparam logic [17:0] ADDR_SPAN = 18'(1) << ADDR_BITS;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    t_len cfg_wdata;

    baa_req_if req_ch ();
    baa_rsp_if rsp_ch ();

    bump_allocator_aligned #(
        .ADDR_BITS(ADDR_BITS),
        .DEFAULT_ALIGN(DEFAULT_ALIGN)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req(req_ch),
        .o_rsp(rsp_ch)
    );

    t_len arena_cap;
    t_len arena_fill;
    t_len arena_peak;
    t_count arena_grants;

    t_rsp pending_rsps[$];
    int fault_count;
    int send_idle_pct;
    int recv_stall_pct;
    logic rsp_hold;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_rsp arena_step(input t_req r);
        t_rsp o;
        logic [17:0] room;
        logic [17:0] align_v;
        logic [17:0] start;
        room = (18'(arena_cap) > ADDR_SPAN) ? ADDR_SPAN : 18'(arena_cap);
        o = '0;
        o.status = ST_OK;
        if (r.func == FUNC_RESET) begin
            arena_fill = '0;
            arena_grants = '0;
        end else begin
            align_v = (r.alignment == '0) ? 18'(DEFAULT_ALIGN) : 18'(r.alignment);
            if (r.size == '0 || (align_v & (align_v - 18'd1)) != '0) begin
                o.status = ST_INVALID;
            end else begin
                start = (18'(arena_fill) + align_v - 18'd1) & ~(align_v - 18'd1);
                if (start > room || 18'(r.size) > room - start) begin
                    o.status = ST_LIMIT;
                end else begin
                    o.offset = start[15:0];
                    arena_fill = t_len'(start + 18'(r.size));
                    if (arena_fill > arena_peak) begin
                        arena_peak = arena_fill;
                    end
                    if (arena_grants != '1) begin
                        arena_grants = arena_grants + 32'd1;
                    end
                end
            end
        end
        o.used_now = arena_fill;
        o.remaining = (18'(arena_fill) > room) ? '0 : t_len'(room - 18'(arena_fill));
        o.peak_now = arena_peak;
        o.grants_now = arena_grants;
        return o;
    endfunction

    function automatic t_req pick_request();
        t_req r;
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(99);
        span = 32'((arena_cap > CAP_RESET) ? CAP_RESET : arena_cap) / 16 + 1;
        r.func = FUNC_ALLOC;
        r.size = t_len'($urandom);
        r.alignment = t_len'($urandom);
        if (roll < 8) begin
            r.func = FUNC_RESET;
        end else if (roll < 76) begin
            r.size = t_len'($urandom_range(1, span));
            r.alignment = ($urandom_range(3) == 0) ? '0 : t_len'(1) << $urandom_range(0, 7);
        end else if (roll < 82) begin
            r.size = '0;
        end else if (roll < 88) begin
            r.size = t_len'($urandom_range(1, span));
        end
        return r;
    endfunction

    task automatic offer_request(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= r.func;
        req_ch.size <= r.size;
        req_ch.alignment <= r.alignment;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        pending_rsps.push_back(arena_step(r));
    endtask

    task automatic alloc(input t_len size, input t_len alignment);
        t_req r;
        r.func = FUNC_ALLOC;
        r.size = size;
        r.alignment = alignment;
        offer_request(r);
    endtask

    task automatic clear_arena();
        t_req r;
        r.func = FUNC_RESET;
        r.size = t_len'($urandom);
        r.alignment = t_len'($urandom);
        offer_request(r);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input t_len value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        arena_cap = value;
    endtask

    task automatic stall_receiver(input int cycles);
        rsp_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rsp_hold <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsps.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("%0t: response item with none outstanding", $realtime);
                end
            end else begin
                want = pending_rsps.pop_front();
                check_field("status", 32'(rsp_ch.status), 32'(want.status));
                check_field("offset", 32'(rsp_ch.offset), 32'(want.offset));
                check_field("used_now", 32'(rsp_ch.used_now), 32'(want.used_now));
                check_field("remaining", 32'(rsp_ch.remaining), 32'(want.remaining));
                check_field("peak_now", 32'(rsp_ch.peak_now), 32'(want.peak_now));
                check_field("grants_now", rsp_ch.grants_now, want.grants_now);
            end
        end
    end

    task automatic test_directed_requests();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        alloc(17'd1, 17'd0);
        alloc(17'd3, 17'd1);
        alloc(17'd16, 17'd0);
        alloc(17'd0, 17'd8);
        alloc(17'd5, 17'd3);
        alloc(17'd0, 17'd3);
        alloc(17'd1, 17'h10000);
        alloc(17'd4, 17'h1FFFF);
        alloc(17'h10000, 17'd0);
        clear_arena();
        alloc(17'h10000, 17'h10000);
        alloc(17'd1, 17'd1);
        clear_arena();
        alloc(17'h1FFFF, 17'd0);
        wait_idle();
    endtask

    task automatic test_capacity_limits();
        write_capacity(17'd0);
        alloc(17'd1, 17'd1);
        clear_arena();
        write_capacity(17'd1);
        alloc(17'd1, 17'd1);
        alloc(17'd1, 17'd1);
        write_capacity(17'h1FFFF);
        clear_arena();
        alloc(17'h10000, 17'd1);
        write_capacity(17'd100);
        alloc(17'd1, 17'd0);
        clear_arena();
        alloc(17'd100, 17'd0);
        wait_idle();
    endtask

    task automatic test_backpressure(input int items);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            stall_receiver(HOLD_CYCLES);
        join_none
        repeat (items) offer_request(pick_request());
        wait_idle();
    endtask

    task automatic test_random_traffic(input int items, input t_len capacity,
                                       input int send_pct, input int recv_pct);
        write_capacity(capacity);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (items) offer_request(pick_request());
        wait_idle();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FUNC_ALLOC;
        req_ch.size <= '0;
        req_ch.alignment <= '0;
        rsp_hold <= 1'b0;
        fault_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        arena_cap = CAP_RESET;
        arena_fill = '0;
        arena_peak = '0;
        arena_grants = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_requests();
        test_capacity_limits();
        test_random_traffic(245, CAP_RESET, 0, 0);
        test_random_traffic(245, 17'd300, 53, 0);
        test_backpressure(40);
        test_random_traffic(245, 17'h1FFFF, 0, 53);
        test_random_traffic(245, t_len'($urandom_range(1, 4096)), 37, 37);

        if (fault_count == 0) begin
            $display("bump_allocator_aligned verification clean");
        end else begin
            $display("bump_allocator_aligned verification failed");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("bump_allocator_aligned verification failed");
        $finish;
    end

endmodule

// ----- bump_allocator_aligned.f -----
src/baa_pkg.sv
src/baa_ifs.sv
src/baa_step.sv
src/bump_allocator_aligned.sv
dv/bump_allocator_aligned_test.sv
